[rtl/core/solf_pkg.sv]
// Shared types, constants and the step program of the second-order lag filter.
package solf_pkg;

   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int STATE_EXTRA      = 8;
   localparam int CFG_WIDTH        = 32;
   localparam int CSR_ADDR_WIDTH   = 4;
   localparam int COEF_WIDTH       = 40;
   localparam int COEF_CHUNK       = COEF_WIDTH / 2;
   localparam int KX_SHIFT         = 8;
   localparam int COEF_SHIFT       = 24;
   localparam int ROOT_WIDTH       = 32;
   localparam int SQRT_STEPS       = ROOT_WIDTH;
   localparam int DIV_WIDTH        = CFG_WIDTH + 1 + COEF_SHIFT;
   localparam int STEP_WIDTH       = 5;

   localparam logic [CFG_WIDTH-1:0] MIN_TC       = 32'd1678;
   localparam logic [CFG_WIDTH-1:0] GAIN_RESET   = 32'h0001_0000;
   localparam logic [CFG_WIDTH-1:0] PERIOD_RESET = 32'd167772;

   typedef enum logic [1:0] {
      REG_GAIN,
      REG_TC_ONE,
      REG_TC_TWO,
      REG_PERIOD
   } reg_idx_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] gain;
      logic [CFG_WIDTH-1:0] tc_one;
      logic [CFG_WIDTH-1:0] tc_two;
      logic [CFG_WIDTH-1:0] period;
   } cfg_regs_type;

   typedef struct packed {
      logic                  busy;
      logic [COEF_WIDTH-1:0] omega_dt;
      logic [COEF_WIDTH-1:0] damping;
   } coef_status_type;

   typedef logic [STEP_WIDTH-1:0] step_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_MLO,
      OP_MHI,
      OP_SAT,
      OP_ERR,
      OP_UPD,
      OP_OUT,
      OP_PASS
   } op_type;

   typedef enum logic [1:0] {
      MS_KX,
      MS_DAMP,
      MS_DY,
      MS_DV
   } msel_type;

   typedef enum logic [1:0] {
      DST_KX,
      DST_PROD,
      DST_DY
   } dst_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_IF_PASS,
      JMP_ALWAYS
   } jmp_type;

   typedef struct packed {
      op_type   op;
      msel_type msel;
      dst_type  dst;
      jmp_type  jmp;
      step_type target;
   } ctrl_word_type;

   localparam step_type STEP_START = 5'd0;
   localparam step_type STEP_PASS  = 5'd16;

   function automatic ctrl_word_type cw_make(input op_type op, input msel_type ms,
                                             input dst_type ds, input jmp_type jp,
                                             input step_type tg);
      ctrl_word_type w;
      w.op     = op;
      w.msel   = ms;
      w.dst    = ds;
      w.jmp    = jp;
      w.target = tg;
      return w;
   endfunction

   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type w;
      case (step)
         5'd0:    w = cw_make(OP_ACCEPT, MS_KX,   DST_KX,   JMP_IF_PASS, STEP_PASS);
         5'd1:    w = cw_make(OP_MLO,    MS_KX,   DST_KX,   JMP_NEXT,    STEP_START);
         5'd2:    w = cw_make(OP_MHI,    MS_KX,   DST_KX,   JMP_NEXT,    STEP_START);
         5'd3:    w = cw_make(OP_SAT,    MS_KX,   DST_KX,   JMP_NEXT,    STEP_START);
         5'd4:    w = cw_make(OP_MLO,    MS_DAMP, DST_PROD, JMP_NEXT,    STEP_START);
         5'd5:    w = cw_make(OP_MHI,    MS_DAMP, DST_PROD, JMP_NEXT,    STEP_START);
         5'd6:    w = cw_make(OP_SAT,    MS_DAMP, DST_PROD, JMP_NEXT,    STEP_START);
         5'd7:    w = cw_make(OP_ERR,    MS_KX,   DST_KX,   JMP_NEXT,    STEP_START);
         5'd8:    w = cw_make(OP_MLO,    MS_DY,   DST_DY,   JMP_NEXT,    STEP_START);
         5'd9:    w = cw_make(OP_MHI,    MS_DY,   DST_DY,   JMP_NEXT,    STEP_START);
         5'd10:   w = cw_make(OP_SAT,    MS_DY,   DST_DY,   JMP_NEXT,    STEP_START);
         5'd11:   w = cw_make(OP_MLO,    MS_DV,   DST_PROD, JMP_NEXT,    STEP_START);
         5'd12:   w = cw_make(OP_MHI,    MS_DV,   DST_PROD, JMP_NEXT,    STEP_START);
         5'd13:   w = cw_make(OP_SAT,    MS_DV,   DST_PROD, JMP_NEXT,    STEP_START);
         5'd14:   w = cw_make(OP_UPD,    MS_KX,   DST_KX,   JMP_NEXT,    STEP_START);
         5'd15:   w = cw_make(OP_OUT,    MS_KX,   DST_KX,   JMP_ALWAYS,  STEP_START);
         5'd16:   w = cw_make(OP_PASS,   MS_KX,   DST_KX,   JMP_ALWAYS,  STEP_START);
         default: w = cw_make(OP_NOP,    MS_KX,   DST_KX,   JMP_ALWAYS,  STEP_START);
      endcase
      return w;
   endfunction

endpackage

[rtl/core/solf_if.sv]
// Valid/ready channel interfaces for the filter's sample and result items.
interface solf_req_if #(
   parameter int W = 32
) ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface solf_rsp_if #(
   parameter int W = 32
) ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] filtered;

   modport source (output valid, output filtered, input ready);
   modport sink   (input valid, input filtered, output ready);
endinterface

[rtl/core/solf_derive.sv]
// Coefficient unit: clamp, multiply, bit-serial square root and two restoring divisions.
module solf_derive (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  solf_pkg::cfg_regs_type        cfg,
   output solf_pkg::coef_status_type     status
);
   import solf_pkg::*;

   typedef enum logic [2:0] {
      ST_MULT,
      ST_SQRT,
      ST_DIV_OD,
      ST_DIV_DC,
      ST_DONE
   } state_type;

   state_type                  state_ff;
   logic [5:0]                 cnt_ff;
   logic [2*ROOT_WIDTH-1:0]    prod_ff;
   logic [ROOT_WIDTH:0]        rem_ff;
   logic [ROOT_WIDTH-1:0]      root_ff;
   logic [DIV_WIDTH-1:0]       dvd_ff;
   logic [DIV_WIDTH-1:0]       quo_ff;
   logic [COEF_WIDTH-1:0]      omega_ff;
   logic [COEF_WIDTH-1:0]      damp_ff;

   logic [CFG_WIDTH-1:0]       t1c;
   logic [CFG_WIDTH-1:0]       t2c;
   logic [CFG_WIDTH:0]         tsum;
   logic [ROOT_WIDTH+2:0]      sq_cur;
   logic [ROOT_WIDTH+2:0]      sq_trial;
   logic [ROOT_WIDTH+2:0]      sq_diff;
   logic                       sq_ge;
   logic [ROOT_WIDTH:0]        dv_cur;
   logic [ROOT_WIDTH:0]        dv_den;
   logic [ROOT_WIDTH:0]        dv_diff;
   logic                       dv_ge;
   logic [DIV_WIDTH-1:0]       quo_next;

   function automatic logic [COEF_WIDTH-1:0] coef_sat(input logic [DIV_WIDTH-1:0] q);
      return (|q[DIV_WIDTH-1:COEF_WIDTH]) ? '1 : q[COEF_WIDTH-1:0];
   endfunction

   always_comb begin
      t1c      = (cfg.tc_one > MIN_TC) ? cfg.tc_one : MIN_TC;
      t2c      = (cfg.tc_two > MIN_TC) ? cfg.tc_two : MIN_TC;
      tsum     = (CFG_WIDTH+1)'(t1c) + (CFG_WIDTH+1)'(t2c);
      sq_cur   = {rem_ff, prod_ff[2*ROOT_WIDTH-1 -: 2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      sq_ge    = (sq_cur >= sq_trial);
      sq_diff  = sq_cur - sq_trial;
      dv_cur   = {rem_ff[ROOT_WIDTH-1:0], dvd_ff[DIV_WIDTH-1]};
      dv_den   = {1'b0, root_ff};
      dv_ge    = (dv_cur >= dv_den);
      dv_diff  = dv_cur - dv_den;
      quo_next = {quo_ff[DIV_WIDTH-2:0], dv_ge};
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         state_ff <= ST_MULT;
      end else begin
         unique case (state_ff)
            ST_MULT: begin
               prod_ff  <= (2*ROOT_WIDTH)'(t1c) * (2*ROOT_WIDTH)'(t2c);
               rem_ff   <= '0;
               root_ff  <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               prod_ff <= {prod_ff[2*ROOT_WIDTH-3:0], 2'b00};
               root_ff <= {root_ff[ROOT_WIDTH-2:0], sq_ge};
               if (cnt_ff == 6'(SQRT_STEPS-1)) begin
                  rem_ff   <= '0;
                  dvd_ff   <= {1'b0, cfg.period, {COEF_SHIFT{1'b0}}};
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV_OD;
               end else begin
                  rem_ff <= sq_ge ? sq_diff[ROOT_WIDTH:0] : sq_cur[ROOT_WIDTH:0];
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            ST_DIV_OD, ST_DIV_DC: begin
               quo_ff <= quo_next;
               if (cnt_ff == 6'(DIV_WIDTH-1)) begin
                  cnt_ff <= '0;
                  rem_ff <= '0;
                  if (state_ff == ST_DIV_OD) begin
                     omega_ff <= coef_sat(quo_next);
                     dvd_ff   <= {tsum, {COEF_SHIFT{1'b0}}};
                     state_ff <= ST_DIV_DC;
                  end else begin
                     damp_ff  <= coef_sat(quo_next);
                     state_ff <= ST_DONE;
                  end
               end else begin
                  rem_ff <= dv_ge ? {1'b0, dv_diff[ROOT_WIDTH-1:0]}
                                  : {1'b0, dv_cur[ROOT_WIDTH-1:0]};
                  dvd_ff <= {dvd_ff[DIV_WIDTH-2:0], 1'b0};
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            ST_DONE: begin
            end
            default: begin
               state_ff <= ST_MULT;
            end
         endcase
      end
   end

   assign status.busy     = (state_ff != ST_DONE);
   assign status.omega_dt = omega_ff;
   assign status.damping  = damp_ff;

endmodule

[rtl/core/second_order_lag_filter.sv]
// Second-order lag filter top level: registers, microcoded sequencer and shared-multiplier datapath.
// Each sample item runs a 16-step program that sends four products through one 40x20 multiplier
// in two passes each (a passthrough item jumps straight to the pass step); a new item is taken only
// once the previous one has left the program, which waits while the result register is still full.
// Reset clears both states; coefficients are then derived, also after every register write, and no
// item is accepted meanwhile.
module second_order_lag_filter #(
   parameter int SAMPLE_WIDTH = solf_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [solf_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [solf_pkg::CFG_WIDTH-1:0]      csr_pwdata,
   output logic [solf_pkg::CFG_WIDTH-1:0]      csr_prdata,
   output logic                                csr_pready,
   solf_req_if.sink                            req_ch,
   solf_rsp_if.source                          rsp_ch
);
   import solf_pkg::*;

   localparam int SW  = SAMPLE_WIDTH;
   localparam int STW = SW + STATE_EXTRA;
   localparam int PW  = STW + COEF_WIDTH;
   localparam int MPW = STW + COEF_CHUNK;

   localparam logic [STW-1:0] STATE_MAX = {1'b0, {(STW-1){1'b1}}};
   localparam logic [STW-1:0] STATE_MIN = {1'b1, {(STW-1){1'b0}}};
   localparam logic [PW-1:0]  LIM_POS   = {{(PW-STW+1){1'b0}}, {(STW-1){1'b1}}};
   localparam logic [PW-1:0]  LIM_NEG   = {{(PW-STW){1'b0}}, 1'b1, {(STW-1){1'b0}}};

   cfg_regs_type            cfg_ff;
   cfg_regs_type            cfg_in;
   logic                    cfg_wr;
   reg_idx_type             csr_idx;
   coef_status_type         coef;

   step_type                step_ff;
   step_type                step_in;
   ctrl_word_type           cw;
   logic                    in_acc;
   logic                    out_free;
   logic                    out_load;
   logic                    hold;
   logic                    pass_mode;

   logic signed [SW-1:0]    x_ff;
   logic signed [STW-1:0]   v_ff;
   logic signed [STW-1:0]   y_ff;
   logic signed [STW-1:0]   kx_ff;
   logic signed [STW-1:0]   prod_ff;
   logic signed [STW-1:0]   dy_ff;
   logic signed [STW-1:0]   err_ff;
   logic [PW-1:0]           acc_ff;
   logic                    neg_ff;
   logic                    rsp_valid_ff;
   logic signed [SW-1:0]    rsp_data_ff;

   logic [SW-1:0]           x_mag;
   logic [CFG_WIDTH-1:0]    g_mag;
   logic [STW-1:0]          v_mag;
   logic [STW-1:0]          e_mag;
   logic [STW-1:0]          a_mag;
   logic [COEF_WIDTH-1:0]   b_op;
   logic [COEF_CHUNK-1:0]   b_chunk;
   logic                    op_neg;
   logic [MPW-1:0]          part;
   logic [PW-1:0]           shifted;
   logic [PW-1:0]           lim;
   logic [PW-1:0]           mag_sat;
   logic signed [STW-1:0]   sat_val;
   logic signed [STW+1:0]   e_wide;
   logic signed [STW-1:0]   e_sat;
   logic signed [STW:0]     v_sum;
   logic signed [STW:0]     y_sum;
   logic signed [STW-1:0]   v_sat;
   logic signed [STW-1:0]   y_sat;
   logic signed [SW-1:0]    out_data;

   // Configuration port
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         unique case (csr_idx)
            REG_GAIN:   cfg_in.gain   = csr_pwdata;
            REG_TC_ONE: cfg_in.tc_one = csr_pwdata;
            REG_TC_TWO: cfg_in.tc_two = csr_pwdata;
            REG_PERIOD: cfg_in.period = csr_pwdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_GAIN:   csr_prdata = cfg_ff.gain;
         REG_TC_ONE: csr_prdata = cfg_ff.tc_one;
         REG_TC_TWO: csr_prdata = cfg_ff.tc_two;
         REG_PERIOD: csr_prdata = cfg_ff.period;
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain   <= GAIN_RESET;
         cfg_ff.tc_one <= '0;
         cfg_ff.tc_two <= '0;
         cfg_ff.period <= PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   solf_derive u_derive (
      .clock  (clock),
      .reset  (reset),
      .start  (cfg_wr),
      .cfg    (cfg_ff),
      .status (coef)
   );

   // Sequencer
   assign cw             = ucode(step_ff);
   assign pass_mode      = (cfg_ff.tc_one == '0) || (cfg_ff.tc_two == '0);
   assign req_ch.ready   = (cw.op == OP_ACCEPT) && !coef.busy;
   assign in_acc         = req_ch.valid && req_ch.ready;
   assign out_free       = !rsp_valid_ff || rsp_ch.ready;
   assign out_load       = ((cw.op == OP_OUT) || (cw.op == OP_PASS)) && out_free;

   always_comb begin
      case (cw.op)
         OP_ACCEPT:       hold = !in_acc;
         OP_OUT, OP_PASS: hold = !out_free;
         default:         hold = 1'b0;
      endcase
      if (hold) begin
         step_in = step_ff;
      end else begin
         unique case (cw.jmp)
            JMP_NEXT:    step_in = step_ff + 1'b1;
            JMP_IF_PASS: step_in = pass_mode ? cw.target : step_ff + 1'b1;
            JMP_ALWAYS:  step_in = cw.target;
            default:     step_in = STEP_START;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_START;
      end else begin
         step_ff <= step_in;
      end
   end

   // Operand select and shared multiplier
   always_comb begin
      x_mag   = x_ff[SW-1] ? SW'(-x_ff) : SW'(x_ff);
      g_mag   = cfg_ff.gain[CFG_WIDTH-1] ? -cfg_ff.gain : cfg_ff.gain;
      v_mag   = v_ff[STW-1] ? STW'(-v_ff) : STW'(v_ff);
      e_mag   = err_ff[STW-1] ? STW'(-err_ff) : STW'(err_ff);
      a_mag   = STW'(x_mag);
      b_op    = COEF_WIDTH'(g_mag);
      op_neg  = x_ff[SW-1] ^ cfg_ff.gain[CFG_WIDTH-1];
      case (cw.msel)
         MS_DAMP: begin
            a_mag  = v_mag;
            b_op   = coef.damping;
            op_neg = v_ff[STW-1];
         end
         MS_DY: begin
            a_mag  = v_mag;
            b_op   = coef.omega_dt;
            op_neg = v_ff[STW-1];
         end
         MS_DV: begin
            a_mag  = e_mag;
            b_op   = coef.omega_dt;
            op_neg = err_ff[STW-1];
         end
         default: begin
         end
      endcase
      b_chunk = (cw.op == OP_MHI) ? b_op[COEF_WIDTH-1:COEF_CHUNK] : b_op[COEF_CHUNK-1:0];
      part    = MPW'(a_mag) * MPW'(b_chunk);
   end

   // Shift, truncate toward zero, saturate
   always_comb begin
      shifted = (cw.msel == MS_KX) ? (acc_ff >> KX_SHIFT) : (acc_ff >> COEF_SHIFT);
      lim     = neg_ff ? LIM_NEG : LIM_POS;
      mag_sat = (shifted > lim) ? lim : shifted;
      sat_val = neg_ff ? -mag_sat[STW-1:0] : mag_sat[STW-1:0];
   end

   always_comb begin
      e_wide = (STW+2)'(kx_ff) - (STW+2)'(y_ff) - (STW+2)'(prod_ff);
      if ((e_wide[STW+1:STW-1] == '0) || (e_wide[STW+1:STW-1] == '1)) begin
         e_sat = e_wide[STW-1:0];
      end else begin
         e_sat = e_wide[STW+1] ? STATE_MIN : STATE_MAX;
      end
      v_sum = (STW+1)'(v_ff) + (STW+1)'(prod_ff);
      y_sum = (STW+1)'(y_ff) + (STW+1)'(dy_ff);
      if (v_sum[STW] == v_sum[STW-1]) begin
         v_sat = v_sum[STW-1:0];
      end else begin
         v_sat = v_sum[STW] ? STATE_MIN : STATE_MAX;
      end
      if (y_sum[STW] == y_sum[STW-1]) begin
         y_sat = y_sum[STW-1:0];
      end else begin
         y_sat = y_sum[STW] ? STATE_MIN : STATE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         x_ff <= req_ch.sample;
      end
      case (cw.op)
         OP_MLO: begin
            acc_ff <= PW'(part);
            neg_ff <= op_neg;
         end
         OP_MHI: begin
            acc_ff <= acc_ff + (PW'(part) << COEF_CHUNK);
         end
         OP_SAT: begin
            case (cw.dst)
               DST_KX:   kx_ff   <= sat_val;
               DST_PROD: prod_ff <= sat_val;
               DST_DY:   dy_ff   <= sat_val;
               default:  prod_ff <= sat_val;
            endcase
         end
         OP_ERR: begin
            err_ff <= e_sat;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         y_ff <= '0;
      end else if (cw.op == OP_UPD) begin
         v_ff <= v_sat;
         y_ff <= y_sat;
      end else if ((cw.op == OP_PASS) && out_free) begin
         y_ff <= {x_ff, {STATE_EXTRA{1'b0}}};
      end
   end

   // Result register
   assign out_data = (cw.op == OP_PASS) ? x_ff : y_ff[STW-1:STATE_EXTRA];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= out_data;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.filtered = rsp_data_ff;

   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("item accepted while the previous one is still in the program");

   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_PASS)
      else $error("step counter left the program");

   a_write_rederives: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> coef.busy)
      else $error("register write did not restart coefficient derivation");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> ($stable(rsp_data_ff) && rsp_valid_ff))
      else $error("pending result overwritten");

endmodule
